@@ rtl/sbdn_pkg.sv @@
// Shared definitions for the spectrum bin dB normalizer.
// Holds field widths, register indexes, reset values, fixed-point constants and enums.
// No dependencies; used by the core and by its checker.
package sbdn_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 32;
  localparam int BIN_W      = 13;
  localparam int LEVEL_W    = 16;
  localparam int WINDOW_W   = 48;
  localparam int NYQ_W      = 13;
  localparam int FLOOR_W    = 17;
  localparam int CEIL_W     = 15;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_ENERGY = 2'd0,
    CFG_NYQUIST_BIN   = 2'd1,
    CFG_FLOOR_DB      = 2'd2,
    CFG_CEILING_DB    = 2'd3
  } cfg_reg_t;

  // Transform limit; a Nyquist setting above half of it is clipped to that half.
  localparam int MAX_TRANSFORM  = 8192;
  localparam int HALF_TRANSFORM = MAX_TRANSFORM / 2;
  localparam int NYQ_CMP_W      = 17;

  // Reset values of the registers.
  localparam logic [NYQ_W-1:0]          NYQUIST_RESET = 13'd1024;
  localparam logic signed [FLOOR_W-1:0] FLOOR_RESET   = -17'sd20480;
  localparam logic signed [CEIL_W-1:0]  CEILING_RESET = 15'sd0;

  // Log2 format: 6 integer bits and 16 fraction bits.
  localparam int FRAC_W = 16;
  localparam int EXP_W  = 6;
  localparam int LOG_W  = EXP_W + FRAC_W;
  localparam logic [LOG_W-1:0] LOG_WINDOW_RESET = {6'd32, 16'd0};

  // dB scaling: 10*log10(2) in Q2.24 and the rounding offset.
  localparam int PROD_W = 51;
  localparam int DB_W   = 19;
  localparam logic signed [26:0]       DB_K     = 27'sd50504453;
  localparam logic signed [PROD_W-1:0] DB_ROUND = 51'sd2147483648;
  localparam logic signed [DB_W-1:0]   TINY_DB  = -19'sd51200;

  // Window log unit states.
  typedef enum logic [1:0] {
    LW_IDLE,
    LW_NORM,
    LW_SQR
  } lw_state_t;

  // How the final level is formed.
  typedef enum logic [1:0] {
    LV_ZERO,
    LV_FULL,
    LV_DIV
  } level_code_t;

endpackage

@@ rtl/spectrum_bin_db_normalizer_core.sv @@
// Spectrum bin to normalized dB level, fully pipelined core.
// Depends on sbdn_pkg for widths, constants and enums.
// A beat passes through 46 register stages, the output register included, once accepted.
// One beat per cycle unless stalled; the log and divide pipelines resolve one bit per stage.
// A window_energy write stalls the input while its log2 is iterated.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
module spectrum_bin_db_normalizer_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [sbdn_pkg::SAMPLE_W-1:0]    in_bin_real,
  input  logic signed [sbdn_pkg::SAMPLE_W-1:0]    in_bin_imag,
  input  logic        [sbdn_pkg::BIN_W-1:0]       in_bin_number,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic        [sbdn_pkg::LEVEL_W-1:0]     out_level,
  output logic                                    out_bad_range,
  input  logic                                    cfg_wr_en,
  input  logic        [sbdn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [sbdn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int MAG_W      = 2 * sbdn_pkg::SAMPLE_W;
  localparam int NORM_STEPS = $clog2(MAG_W);
  localparam int SQ_STEPS   = sbdn_pkg::FRAC_W;
  localparam int DIV_STEPS  = sbdn_pkg::LEVEL_W;
  localparam int RANGE_W    = sbdn_pkg::FLOOR_W + 1;
  localparam int DIV_W      = RANGE_W - 1;
  localparam int NUM_W      = sbdn_pkg::DB_W + 1;
  localparam int P_W        = sbdn_pkg::LOG_W + 2;
  localparam int STEP_W     = $clog2(SQ_STEPS);
  localparam int MANT_W     = sbdn_pkg::SAMPLE_W;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SQ_STEPS - 1);

  // Configuration registers and derived range.
  logic        [sbdn_pkg::NYQ_W-1:0]   nyquist_bin_r;
  logic signed [sbdn_pkg::FLOOR_W-1:0] floor_db_r;
  logic signed [sbdn_pkg::CEIL_W-1:0]  ceiling_db_r;
  logic signed [RANGE_W-1:0]           range_d_r;
  logic                                bad_cfg_r;

  // Window log unit.
  sbdn_pkg::lw_state_t                 lw_state_r, lw_state_nxt;
  logic [sbdn_pkg::WINDOW_W-1:0]       lw_x_r;
  logic [sbdn_pkg::EXP_W-1:0]          lw_exp_r;
  logic [MANT_W-1:0]                   lw_mant_r, lw_mant_nxt;
  logic [sbdn_pkg::FRAC_W-1:0]         lw_frac_r, lw_frac_nxt;
  logic [STEP_W-1:0]                   lw_step_r;
  logic [sbdn_pkg::LOG_W-1:0]          log_w_r;
  logic [MAG_W-1:0]                    lw_sq;
  logic                                lw_bit;
  logic                                lw_load;
  logic                                lw_busy;

  // Pipeline control.
  logic out_load;
  logic adv;
  logic acc;

  // Input stage: magnitudes and flags.
  logic [sbdn_pkg::NYQ_CMP_W-1:0] nyq_eff;
  logic                           in_dbl;
  logic                           a_v_r, a_dbl_r, a_zero_r;
  logic [sbdn_pkg::SAMPLE_W-1:0]  a_re_r, a_im_r;

  // Square stage.
  logic             b_v_r, b_dbl_r, b_zero_r;
  logic [MAG_W-1:0] b_sqr_r, b_sqi_r;

  // Normalize stages; element 0 holds the sum of the squares.
  logic [NORM_STEPS:0]        n_v_r, n_dbl_r, n_zero_r;
  logic [MAG_W-1:0]           n_x_r   [NORM_STEPS+1];
  logic [sbdn_pkg::EXP_W-1:0] n_cnt_r [NORM_STEPS+1];

  // Squaring stages for the log fraction.
  logic [SQ_STEPS-1:0]         s_v_r, s_dbl_r, s_zero_r;
  logic [MANT_W-1:0]           s_mant_r [SQ_STEPS];
  logic [sbdn_pkg::FRAC_W-1:0] s_frac_r [SQ_STEPS];
  logic [sbdn_pkg::EXP_W-1:0]  s_exp_r  [SQ_STEPS];

  // Log difference, dB product and dB value.
  logic                              p_v_r, p_zero_r;
  logic signed [P_W-1:0]             p_val_r;
  logic                              k_v_r, k_zero_r;
  logic signed [sbdn_pkg::PROD_W-1:0] k_prod_r;
  logic signed [sbdn_pkg::PROD_W-1:0] k_round;
  logic                              db_v_r, db_zero_r;
  logic signed [sbdn_pkg::DB_W-1:0]  db_val_r;

  // Range check stage.
  logic signed [NUM_W-1:0]  f_num;
  sbdn_pkg::level_code_t    f_code;
  logic                     f_v_r, f_bad_r;
  sbdn_pkg::level_code_t    f_code_r;
  logic [DIV_W-1:0]         f_rem_r;

  // Divide stages.
  logic [DIV_STEPS-1:0]       v_v_r, v_bad_r;
  sbdn_pkg::level_code_t      v_code_r [DIV_STEPS];
  logic [DIV_W-1:0]           v_rem_r  [DIV_STEPS];
  logic [sbdn_pkg::LEVEL_W-1:0] v_q_r  [DIV_STEPS];

  // Output register.
  logic                         out_valid_r;
  logic [sbdn_pkg::LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic                         out_bad_range_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nyquist_bin_r <= sbdn_pkg::NYQUIST_RESET;
      floor_db_r    <= sbdn_pkg::FLOOR_RESET;
      ceiling_db_r  <= sbdn_pkg::CEILING_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sbdn_pkg::CFG_NYQUIST_BIN: begin
          nyquist_bin_r <= cfg_data[sbdn_pkg::NYQ_W-1:0];
        end
        sbdn_pkg::CFG_FLOOR_DB: begin
          floor_db_r <= $signed(cfg_data[sbdn_pkg::FLOOR_W-1:0]);
        end
        sbdn_pkg::CFG_CEILING_DB: begin
          ceiling_db_r <= $signed(cfg_data[sbdn_pkg::CEIL_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // The user keeps the dB span fixed while items flow (unenforced); it is recomputed every cycle.
  always_ff @(posedge clk) begin
    range_d_r <= RANGE_W'(ceiling_db_r) - RANGE_W'(floor_db_r);
    bad_cfg_r <= (RANGE_W'(ceiling_db_r) <= RANGE_W'(floor_db_r));
  end

  // Window log unit: normalize one bit per cycle, then one squaring per fraction bit.
  assign lw_load = cfg_wr_en && (cfg_index == sbdn_pkg::CFG_WINDOW_ENERGY);

  always_comb begin
    lw_state_nxt = lw_state_r;
    case (lw_state_r)
      sbdn_pkg::LW_IDLE: begin
        lw_state_nxt = sbdn_pkg::LW_IDLE;
      end
      sbdn_pkg::LW_NORM: begin
        if (lw_x_r[sbdn_pkg::WINDOW_W-1]) lw_state_nxt = sbdn_pkg::LW_SQR;
      end
      sbdn_pkg::LW_SQR: begin
        if (lw_step_r == STEP_LAST) lw_state_nxt = sbdn_pkg::LW_IDLE;
      end
      default: begin
        lw_state_nxt = sbdn_pkg::LW_IDLE;
      end
    endcase
    if (lw_load) lw_state_nxt = sbdn_pkg::LW_NORM;
    lw_busy = (lw_state_r != sbdn_pkg::LW_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_state_r <= sbdn_pkg::LW_IDLE;
    end else begin
      lw_state_r <= lw_state_nxt;
    end
  end

  assign lw_sq       = MAG_W'(lw_mant_r) * MAG_W'(lw_mant_r);
  assign lw_bit      = lw_sq[MAG_W-1];
  assign lw_mant_nxt = lw_bit ? lw_sq[MAG_W-1 -: MANT_W] : lw_sq[MAG_W-2 -: MANT_W];
  assign lw_frac_nxt = {lw_frac_r[sbdn_pkg::FRAC_W-2:0], lw_bit};

  always_ff @(posedge clk) begin
    if (lw_load) begin
      // A zero window energy counts as one unit.
      lw_x_r   <= (cfg_data == '0) ? sbdn_pkg::WINDOW_W'(1) : cfg_data[sbdn_pkg::WINDOW_W-1:0];
      lw_exp_r <= sbdn_pkg::EXP_W'(sbdn_pkg::WINDOW_W - 1);
    end else if (lw_state_r == sbdn_pkg::LW_NORM) begin
      if (!lw_x_r[sbdn_pkg::WINDOW_W-1]) begin
        lw_x_r   <= lw_x_r << 1;
        lw_exp_r <= lw_exp_r - sbdn_pkg::EXP_W'(1);
      end
      lw_mant_r <= lw_x_r[sbdn_pkg::WINDOW_W-1 -: MANT_W];
      lw_frac_r <= '0;
      lw_step_r <= '0;
    end else if (lw_state_r == sbdn_pkg::LW_SQR) begin
      lw_mant_r <= lw_mant_nxt;
      lw_frac_r <= lw_frac_nxt;
      lw_step_r <= lw_step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_w_r <= sbdn_pkg::LOG_WINDOW_RESET;
    end else if (lw_state_r == sbdn_pkg::LW_SQR && lw_step_r == STEP_LAST) begin
      log_w_r <= {lw_exp_r, lw_frac_nxt};
    end
  end

  // Pipeline advance: everything moves unless the output beat is stalled and the last stage is full.
  assign out_load = !out_valid_r || !out_stall;
  assign adv      = out_load || !v_v_r[DIV_STEPS-1];
  assign in_stall = !adv || lw_busy;
  assign acc      = in_valid && !in_stall;

  // Doubling applies strictly between DC and the clipped Nyquist bin.
  always_comb begin
    if (sbdn_pkg::NYQ_CMP_W'(nyquist_bin_r) > sbdn_pkg::NYQ_CMP_W'(sbdn_pkg::HALF_TRANSFORM)) begin
      nyq_eff = sbdn_pkg::NYQ_CMP_W'(sbdn_pkg::HALF_TRANSFORM);
    end else begin
      nyq_eff = sbdn_pkg::NYQ_CMP_W'(nyquist_bin_r);
    end
    in_dbl = (in_bin_number != '0) && (sbdn_pkg::NYQ_CMP_W'(in_bin_number) < nyq_eff);
  end

  // Valid bits for the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      b_v_r    <= 1'b0;
      n_v_r[0] <= 1'b0;
    end else if (adv) begin
      a_v_r    <= acc;
      b_v_r    <= a_v_r;
      n_v_r[0] <= b_v_r;
    end
  end

  // Front payload: magnitudes, squares and their sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_re_r      <= in_bin_real[sbdn_pkg::SAMPLE_W-1] ?
                     sbdn_pkg::SAMPLE_W'(-in_bin_real) : sbdn_pkg::SAMPLE_W'(in_bin_real);
      a_im_r      <= in_bin_imag[sbdn_pkg::SAMPLE_W-1] ?
                     sbdn_pkg::SAMPLE_W'(-in_bin_imag) : sbdn_pkg::SAMPLE_W'(in_bin_imag);
      a_dbl_r     <= in_dbl;
      a_zero_r    <= (in_bin_real == '0) && (in_bin_imag == '0);
      b_sqr_r     <= MAG_W'(a_re_r) * MAG_W'(a_re_r);
      b_sqi_r     <= MAG_W'(a_im_r) * MAG_W'(a_im_r);
      b_dbl_r     <= a_dbl_r;
      b_zero_r    <= a_zero_r;
      n_x_r[0]    <= b_sqr_r + b_sqi_r;
      n_cnt_r[0]  <= '0;
      n_dbl_r[0]  <= b_dbl_r;
      n_zero_r[0] <= b_zero_r;
    end
  end

  // Leading-one search: each stage tries a shift of half the previous one.
  for (genvar i = 1; i <= NORM_STEPS; i++) begin : g_norm
    localparam int SH = (MAG_W / 2) >> (i - 1);
    logic hit;

    assign hit = (n_x_r[i-1][MAG_W-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        n_v_r[i] <= 1'b0;
      end else if (adv) begin
        n_v_r[i] <= n_v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_x_r[i]    <= hit ? (n_x_r[i-1] << SH) : n_x_r[i-1];
        n_cnt_r[i]  <= hit ? (n_cnt_r[i-1] + sbdn_pkg::EXP_W'(SH)) : n_cnt_r[i-1];
        n_dbl_r[i]  <= n_dbl_r[i-1];
        n_zero_r[i] <= n_zero_r[i-1];
      end
    end
  end

  // Log fraction: one squaring of the Q1.31 mantissa per stage yields one bit.
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqr
    logic [MANT_W-1:0]           mant_in;
    logic [sbdn_pkg::FRAC_W-1:0] frac_in;
    logic [sbdn_pkg::EXP_W-1:0]  exp_in;
    logic                        v_in, dbl_in, zero_in;
    logic [MAG_W-1:0]            sq;
    logic                        bit_out;

    if (j == 0) begin : g_first
      assign mant_in = n_x_r[NORM_STEPS][MAG_W-1 -: MANT_W];
      assign frac_in = '0;
      assign exp_in  = sbdn_pkg::EXP_W'(MAG_W - 1) - n_cnt_r[NORM_STEPS];
      assign v_in    = n_v_r[NORM_STEPS];
      assign dbl_in  = n_dbl_r[NORM_STEPS];
      assign zero_in = n_zero_r[NORM_STEPS];
    end else begin : g_next
      assign mant_in = s_mant_r[j-1];
      assign frac_in = s_frac_r[j-1];
      assign exp_in  = s_exp_r[j-1];
      assign v_in    = s_v_r[j-1];
      assign dbl_in  = s_dbl_r[j-1];
      assign zero_in = s_zero_r[j-1];
    end

    assign sq      = MAG_W'(mant_in) * MAG_W'(mant_in);
    assign bit_out = sq[MAG_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v_r[j] <= 1'b0;
      end else if (adv) begin
        s_v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_mant_r[j] <= bit_out ? sq[MAG_W-1 -: MANT_W] : sq[MAG_W-2 -: MANT_W];
        s_frac_r[j] <= {frac_in[sbdn_pkg::FRAC_W-2:0], bit_out};
        s_exp_r[j]  <= exp_in;
        s_dbl_r[j]  <= dbl_in;
        s_zero_r[j] <= zero_in;
      end
    end
  end

  // Log difference, dB scaling and rounding.
  assign k_round = k_prod_r + sbdn_pkg::DB_ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r  <= 1'b0;
      k_v_r  <= 1'b0;
      db_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r  <= s_v_r[SQ_STEPS-1];
      k_v_r  <= p_v_r;
      db_v_r <= k_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_val_r   <= $signed({2'b00, s_exp_r[SQ_STEPS-1], s_frac_r[SQ_STEPS-1]})
                 - $signed({2'b00, log_w_r})
                 + (s_dbl_r[SQ_STEPS-1] ? P_W'(65536) : P_W'(0));
      p_zero_r  <= s_zero_r[SQ_STEPS-1];
      k_prod_r  <= sbdn_pkg::PROD_W'(p_val_r) * sbdn_pkg::PROD_W'(sbdn_pkg::DB_K);
      k_zero_r  <= p_zero_r;
      db_val_r  <= k_round[sbdn_pkg::PROD_W-1 -: sbdn_pkg::DB_W];
      db_zero_r <= k_zero_r;
    end
  end

  // Range check: decide zero, full scale or a fraction to divide out.
  assign f_num = NUM_W'(db_val_r) - NUM_W'(floor_db_r);

  always_comb begin
    if (bad_cfg_r || db_zero_r || (db_val_r < sbdn_pkg::TINY_DB) || (f_num <= 0)) begin
      f_code = sbdn_pkg::LV_ZERO;
    end else if (f_num >= NUM_W'(range_d_r)) begin
      f_code = sbdn_pkg::LV_FULL;
    end else begin
      f_code = sbdn_pkg::LV_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= db_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_code_r <= f_code;
      f_rem_r  <= f_num[DIV_W-1:0];
      f_bad_r  <= bad_cfg_r;
    end
  end

  // Restoring division of the fraction by the dB span, one quotient bit per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DIV_W-1:0]             rem_in;
    logic [sbdn_pkg::LEVEL_W-1:0] q_in;
    sbdn_pkg::level_code_t        code_in;
    logic                         v_in, bad_in;
    logic [DIV_W:0]               rem2;
    logic                         ge;

    if (k == 0) begin : g_first
      assign rem_in  = f_rem_r;
      assign q_in    = '0;
      assign code_in = f_code_r;
      assign v_in    = f_v_r;
      assign bad_in  = f_bad_r;
    end else begin : g_next
      assign rem_in  = v_rem_r[k-1];
      assign q_in    = v_q_r[k-1];
      assign code_in = v_code_r[k-1];
      assign v_in    = v_v_r[k-1];
      assign bad_in  = v_bad_r[k-1];
    end

    assign rem2 = {rem_in, 1'b0};
    assign ge   = (rem2 >= {1'b0, range_d_r[DIV_W-1:0]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_v_r[k] <= 1'b0;
      end else if (adv) begin
        v_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        v_rem_r[k]  <= ge ? DIV_W'(rem2 - {1'b0, range_d_r[DIV_W-1:0]}) : rem2[DIV_W-1:0];
        v_q_r[k]    <= {q_in[sbdn_pkg::LEVEL_W-2:0], ge};
        v_code_r[k] <= code_in;
        v_bad_r[k]  <= bad_in;
      end
    end
  end

  // Final level selection.
  always_comb begin
    case (v_code_r[DIV_STEPS-1])
      sbdn_pkg::LV_ZERO: out_level_nxt = '0;
      sbdn_pkg::LV_FULL: out_level_nxt = '1;
      sbdn_pkg::LV_DIV:  out_level_nxt = v_q_r[DIV_STEPS-1];
      default:           out_level_nxt = '0;
    endcase
  end

  // Output register holds a beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= v_v_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level_r     <= out_level_nxt;
      out_bad_range_r <= v_bad_r[DIV_STEPS-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_level_r;
  assign out_bad_range = out_bad_range_r;

endmodule

@@ rtl/sbdn_checker.sv @@
// Port-level checker for the spectrum bin dB normalizer core, with its bind.
// Depends on sbdn_pkg for the register index names.
// Watches the output beat, the window-log stall, reset and the bad-range result.
module sbdn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [sbdn_pkg::LEVEL_W-1:0]       out_level,
  input logic                               out_bad_range,
  input logic                               cfg_wr_en,
  input logic [sbdn_pkg::CFG_IDX_W-1:0]     cfg_index
);

  // A stalled output beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level) && $stable(out_bad_range))
    else $error("output beat changed while stalled");

  // A window energy write holds the input off while its log2 is computed.
  a_window_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && (cfg_index == sbdn_pkg::CFG_WINDOW_ENERGY) |=> in_stall ##16 in_stall)
    else $error("input taken while the window log was being computed");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // A bad dB range always reports level zero.
  a_bad_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_range |-> out_level == '0)
    else $error("bad range beat with nonzero level");

endmodule

bind spectrum_bin_db_normalizer_core sbdn_checker u_sbdn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_level     (out_level),
  .out_bad_range (out_bad_range),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_index     (cfg_index)
);
